FILE: design/ipd_rdf_pkg.sv
// shared types, constants and helpers of the receive data filter
package ipd_rdf_pkg;

   // default width of the payload length counter
   localparam int LEN_BITS_DEF = 16;

   // header "+IPD," and the delimiters that follow it
   localparam logic [2:0] HDR_LEN    = 3'd5;
   localparam logic [7:0] CHR_COLON  = 8'h3a;
   localparam logic [7:0] CHR_COMMA  = 8'h2c;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_NINE   = 8'h39;
   localparam logic [3:0] DEC_RADIX  = 4'd10;
   localparam logic [7:0] ID_MAX     = 8'hff;
   localparam logic [15:0] LOSS_MAX  = 16'hffff;

   // parser phases, one-hot
   typedef enum logic [3:0] {
      PH_SEARCH = 4'b0001,
      PH_ID     = 4'b0010,
      PH_LEN    = 4'b0100,
      PH_DATA   = 4'b1000
   } phase_type;

   // where a byte goes
   typedef enum logic [1:0] {
      ROUTE_CMD  = 2'd0,
      ROUTE_DATA = 2'd1,
      ROUTE_DROP = 2'd2
   } route_type;

   // one accepted request
   typedef struct packed {
      logic       data_full;
      logic [7:0] rx_byte;
   } item_type;

   // one result
   typedef struct packed {
      logic [15:0] loss_total;
      logic [15:0] announced_len;
      logic        announce;
      logic        lost;
      route_type   route;
      logic [7:0]  byte_out;
   } result_type;

   // header character at a match position
   function automatic logic [7:0] hdr_char(input logic [2:0] pos);
      logic [7:0] chr;
      unique case (pos)
         3'd0:    chr = 8'h2b;
         3'd1:    chr = 8'h49;
         3'd2:    chr = 8'h50;
         3'd3:    chr = 8'h44;
         3'd4:    chr = 8'h2c;
         default: chr = 8'h2b;
      endcase
      return chr;
   endfunction

endpackage

FILE: design/ipd_receive_data_filter_top.sv
// top level of the receive data filter: input register, parser, result register
//
// Each request carries one modem byte and gives exactly one result: it is held in the
// input register, then the parser updates its state and the result register loads in
// the same edge. A request can be accepted every clock, a result waiting on rsp_tready
// holds the request behind it in the input register, and nothing iterates. csr_data
// sets multi-connection mode; the user writes it only while idle, not enforced here.
module ipd_receive_data_filter_top
   import ipd_rdf_pkg::*;
#(
   parameter int LEN_BITS = LEN_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] rx_byte, [8] data_full, rest zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [7:0] byte_out, [8] lost, [9] announce,
                                    // [25:10] announced_len, [41:26] loss_total
   output logic [1:0]  rsp_tuser,   // [1:0] route
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data     // [0] mux_mode
);

   logic       item_valid;
   item_type   item;
   logic       advance;
   result_type result;
   result_type out_ff;
   logic       out_valid_ff, out_valid_in;
   logic       mux_mode_ff;

   // move the held request on when the result register is free
   assign advance = item_valid && (!out_valid_ff || rsp_tready);

   ipd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   ipd_parser #(
      .LEN_BITS (LEN_BITS)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .mux_mode (mux_mode_ff),
      .step     (advance),
      .item     (item),
      .result   (result)
   );

   // mode register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mux_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         mux_mode_ff <= csr_data;
      end
   end

   // result register
   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.route;
   assign rsp_tdata  = {6'b0, out_ff.loss_total, out_ff.announced_len,
                        out_ff.announce, out_ff.lost, out_ff.byte_out};

   // a lost byte is always discarded
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_ff.lost |-> out_ff.route == ROUTE_DROP)
      else $error("lost byte not discarded");

   // a length appears only with its announcement
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !out_ff.announce |-> out_ff.announced_len == 16'd0)
      else $error("length without announce");

   // a stalled result blocks the input register when it is occupied
   assert property (@(posedge clock) disable iff (reset)
      item_valid && out_valid_ff && !rsp_tready |-> !req_tready && !advance)
      else $error("request accepted over a stalled result");

   // a result follows every request that leaves the input register
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("result missing after request");

endmodule

FILE: design/ipd_in_stage.sv
// input register of the receive data filter
module ipd_in_stage
   import ipd_rdf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] rx_byte, [8] data_full, rest zero
   input  logic        advance,
   output logic        item_valid,
   output item_type    item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // free when empty or when the held request moves on this cycle
   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_tvalid && req_tready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload register
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.rx_byte   <= req_tdata[7:0];
         item_ff.data_full <= req_tdata[8];
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: design/ipd_parser.sv
// header search, id and length parsing and payload routing for one byte
module ipd_parser
   import ipd_rdf_pkg::*;
#(
   parameter int LEN_BITS = LEN_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       mux_mode,
   input  logic       step,
   input  item_type   item,
   output result_type result
);

   phase_type           phase_ff, phase_in;
   logic [2:0]          match_ff, match_in;
   logic [7:0]          id_ff, id_in;
   logic [LEN_BITS-1:0] rem_ff, rem_in;
   logic [15:0]         loss_ff, loss_in;

   logic [7:0]           chr;
   logic                 digit;
   logic [3:0]           dval;
   logic [11:0]          id_prod;
   logic [LEN_BITS+3:0]  rem_prod;
   logic [2:0]           mi;
   logic [2:0]           mi_next;
   logic                 done;
   route_type            route;
   logic                 lost;
   logic                 announce;
   logic [LEN_BITS-1:0]  alen;
   logic [LEN_BITS+15:0] alen_ext;

   // decimal digit and the saturating accumulations
   assign chr      = item.rx_byte;
   assign digit    = (chr >= CHR_ZERO) && (chr <= CHR_NINE);
   assign dval     = chr[3:0];
   assign id_prod  = {4'b0, id_ff} * {8'b0, DEC_RADIX} + {8'b0, dval};
   assign rem_prod = {4'b0, rem_ff} * (LEN_BITS+4)'(DEC_RADIX)
                     + (LEN_BITS+4)'(dval);
   assign mi       = (match_ff < HDR_LEN) ? match_ff : 3'd0;
   assign mi_next  = mi + 3'd1;

   // next state and result of one byte
   always_comb begin
      phase_in = phase_ff;
      match_in = match_ff;
      id_in    = id_ff;
      rem_in   = rem_ff;
      loss_in  = loss_ff;
      route    = ROUTE_CMD;
      lost     = 1'b0;
      announce = 1'b0;
      alen     = '0;
      done     = 1'b0;

      // payload bytes
      if (phase_ff == PH_DATA) begin
         if (rem_ff != '0) begin
            if (id_ff == 8'd0) begin
               if (item.data_full) begin
                  route = ROUTE_DROP;
                  lost  = 1'b1;
                  if (loss_ff != LOSS_MAX) begin
                     loss_in = loss_ff + 16'd1;
                  end
               end else begin
                  route = ROUTE_DATA;
               end
            end else begin
               route = ROUTE_DROP;
            end
            rem_in = rem_ff - LEN_BITS'(1);
            done   = 1'b1;
         end else begin
            phase_in = PH_SEARCH;
         end
      end

      // header bytes
      if (!done) begin
         priority if (phase_in == PH_SEARCH) begin
            if (chr == hdr_char(mi)) begin
               if (mi_next == HDR_LEN) begin
                  phase_in = mux_mode ? PH_ID : PH_LEN;
                  match_in = 3'd0;
                  id_in    = 8'd0;
                  rem_in   = '0;
               end else begin
                  match_in = mi_next;
               end
            end else begin
               match_in = 3'd0;
            end
         end else if (phase_in == PH_ID) begin
            if (digit) begin
               id_in = (id_prod > {4'b0, ID_MAX}) ? ID_MAX : id_prod[7:0];
            end else if (chr == CHR_COMMA) begin
               phase_in = PH_LEN;
            end else begin
               id_in    = 8'd0;
               phase_in = PH_SEARCH;
            end
         end else begin
            if (digit) begin
               rem_in = (rem_prod[LEN_BITS+3:LEN_BITS] != 4'd0) ? '1
                        : rem_prod[LEN_BITS-1:0];
            end else if (chr == CHR_COLON) begin
               phase_in = PH_DATA;
               announce = 1'b1;
               alen     = rem_ff;
            end else begin
               id_in    = 8'd0;
               rem_in   = '0;
               phase_in = PH_SEARCH;
            end
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SEARCH;
         match_ff <= 3'd0;
         id_ff    <= 8'd0;
         rem_ff   <= '0;
         loss_ff  <= 16'd0;
      end else if (step) begin
         phase_ff <= phase_in;
         match_ff <= match_in;
         id_ff    <= id_in;
         rem_ff   <= rem_in;
         loss_ff  <= loss_in;
      end
   end

   // low sixteen bits of the announced length
   assign alen_ext = {16'b0, alen};

   assign result.byte_out      = chr;
   assign result.route         = route;
   assign result.lost          = lost;
   assign result.announce      = announce;
   assign result.announced_len = alen_ext[15:0];
   assign result.loss_total    = loss_in;

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the receive data filter, driven as byte requests
import ipd_rdf_pkg::*;

// tracks the header parser and checks each result against the oldest expected one
class filter_scoreboard;
   string       hdr_text = "+IPD,";
   logic        mux_mode;
   phase_type   phase;
   int unsigned match_pos;
   int unsigned stream_id;
   int unsigned remaining;
   int unsigned loss_count;
   result_type  pending_q[$];
   int unsigned errors;
   int unsigned checked;
   int unsigned announced;

   function new();
      mux_mode   = 1'b0;
      phase      = PH_SEARCH;
      match_pos  = 0;
      stream_id  = 0;
      remaining  = 0;
      loss_count = 0;
      errors     = 0;
      checked    = 0;
      announced  = 0;
   endfunction

   // parse one accepted request and queue the result it should give
   function void note_request(logic [7:0] rx, logic full);
      result_type  exp;
      bit          taken;
      bit          digit;
      int unsigned val;
      exp          = '0;
      exp.byte_out = rx;
      exp.route    = ROUTE_CMD;
      digit        = (rx >= CHR_ZERO) && (rx <= CHR_NINE);
      taken        = 1'b0;
      // payload bytes, or the end of a payload
      if (phase == PH_DATA) begin
         if (remaining != 0) begin
            if (stream_id == 0) begin
               if (full) begin
                  exp.route = ROUTE_DROP;
                  exp.lost  = 1'b1;
                  if (loss_count < LOSS_MAX) loss_count++;
               end else begin
                  exp.route = ROUTE_DATA;
               end
            end else begin
               exp.route = ROUTE_DROP;
            end
            remaining--;
            taken = 1'b1;
         end else begin
            phase = PH_SEARCH;
         end
      end
      // header search, connection id and length fields
      if (!taken) begin
         case (phase)
            PH_SEARCH: begin
               if (rx == hdr_text[match_pos]) begin
                  match_pos++;
                  if (match_pos == HDR_LEN) begin
                     phase     = mux_mode ? PH_ID : PH_LEN;
                     match_pos = 0;
                     stream_id = 0;
                     remaining = 0;
                  end
               end else begin
                  match_pos = 0;
               end
            end
            PH_ID: begin
               if (digit) begin
                  val       = stream_id * DEC_RADIX + (rx - CHR_ZERO);
                  stream_id = (val > ID_MAX) ? ID_MAX : val;
               end else if (rx == CHR_COMMA) begin
                  phase = PH_LEN;
               end else begin
                  stream_id = 0;
                  phase     = PH_SEARCH;
               end
            end
            default: begin
               if (digit) begin
                  val       = remaining * DEC_RADIX + (rx - CHR_ZERO);
                  remaining = (val > (32'd1 << LEN_BITS_DEF) - 1) ?
                              (32'd1 << LEN_BITS_DEF) - 1 : val;
               end else if (rx == CHR_COLON) begin
                  phase             = PH_DATA;
                  exp.announce      = 1'b1;
                  exp.announced_len = remaining[15:0];
               end else begin
                  stream_id = 0;
                  remaining = 0;
                  phase     = PH_SEARCH;
               end
            end
         endcase
      end
      exp.loss_total = loss_count[15:0];
      pending_q.push_back(exp);
   endfunction

   // compare one result with the oldest expectation
   function void check_result(result_type got);
      result_type exp;
      if (pending_q.size() == 0) begin
         $display("%0t: result with nothing expected, byte %h route %0d",
                  $time, got.byte_out, got.route);
         errors++;
         return;
      end
      exp = pending_q.pop_front();
      checked++;
      if (exp.announce) announced++;
      check_field("byte_out", exp.byte_out, got.byte_out);
      check_field("route", exp.route, got.route);
      check_field("lost", exp.lost, got.lost);
      check_field("announce", exp.announce, got.announce);
      check_field("announced_len", exp.announced_len, got.announced_len);
      check_field("loss_total", exp.loss_total, got.loss_total);
   endfunction

   function void check_field(string what, int unsigned want, int unsigned seen);
      if (want != seen) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, seen);
         errors++;
      end
   endfunction
endclass

module testbench;
   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned RANDOM_ITEMS = 1300;
   localparam int unsigned REFUSED_RUN  = 40;
   localparam int unsigned HOLD_AFTER   = 400;
   localparam int unsigned HOLD_CYCLES  = 80;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;    // [7:0] rx_byte, [8] data_full
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [47:0] rsp_tdata;    // [7:0] byte_out, [8] lost, [9] announce,
                              // [25:10] announced_len, [41:26] loss_total
   logic [1:0]  rsp_tuser;    // [1:0] route
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_data;     // [0] mux_mode

   filter_scoreboard board;
   bit               calm = 1'b0;
   int unsigned      cycles = 0;
   int unsigned      sent = 0;
   int unsigned      results_seen = 0;

   ipd_receive_data_filter_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   // clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, board.pending_q.size());
         $display("Verification failed");
         $finish;
      end
   end

   // result monitor
   always @(posedge clock) begin : monitor
      result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.byte_out      = rsp_tdata[7:0];
         got.lost          = rsp_tdata[8];
         got.announce      = rsp_tdata[9];
         got.announced_len = rsp_tdata[25:10];
         got.loss_total    = rsp_tdata[41:26];
         got.route         = route_type'(rsp_tuser);
         board.check_result(got);
         results_seen++;
      end
   end

   // receiver: random stalls, one long hold-off while requests keep coming
   initial begin : receiver
      bit held;
      held       = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!held && results_seen >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         rsp_tready <= calm || ($urandom_range(99) >= 22);
      end
   end

   function automatic logic pick_full();
      return $urandom_range(99) < 25;
   endfunction

   function automatic logic [7:0] pick_byte();
      return 8'($urandom_range(255));
   endfunction

   // offer one byte request and wait for it to be taken
   task automatic push_byte(input logic [7:0] rx, input logic full);
      while (!calm && $urandom_range(99) < 22) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tdata  <= {7'd0, full, rx};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      board.note_request(rx, full);
      sent++;
      @(negedge clock);
   endtask

   task automatic push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) push_byte(s[i], pick_full());
   endtask

   // let every outstanding result come back, then allow the pipeline to settle
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.pending_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_mux(input logic mode);
      drain();
      csr_data  <= mode;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      board.mux_mode = mode;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // one random frame: mostly well formed, some cut short, some line noise
   task automatic push_frame(input logic mux);
      int unsigned kind;
      int unsigned id;
      int unsigned len;
      int unsigned cut;
      string       s;
      kind = $urandom_range(99);
      s    = "+IPD,";
      if (mux) begin
         if ($urandom_range(1) == 1) id = 0;
         else if ($urandom_range(9) == 0) id = $urandom_range(256, 999);
         else id = $urandom_range(1, 4);
         if ($urandom_range(7) == 0) s = $sformatf("%s0", s);
         s = $sformatf("%s%0d,", s, id);
      end
      len = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
      if ($urandom_range(7) == 0) s = $sformatf("%s0", s);
      s = $sformatf("%s%0d:", s, len);
      if (kind < 72) begin
         push_text(s);
         repeat (len) push_byte(pick_byte(), pick_full());
      end else if (kind < 88) begin
         // header broken off by a stray byte
         cut = $urandom_range(1, s.len() - 1);
         push_text(s.substr(0, cut - 1));
         case ($urandom_range(2))
            0:       push_byte("x", pick_full());
            1:       push_byte(CHR_COMMA, pick_full());
            default: push_byte(pick_byte(), pick_full());
         endcase
      end else begin
         repeat ($urandom_range(1, 6)) push_byte(pick_byte(), pick_full());
      end
   endtask

   // stimulus
   initial begin : stimulus
      int unsigned phase_no;
      int unsigned target;
      board      = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_data   = 1'b0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // directed: payload edges, header mismatch, zero length, bad length character
      write_mux(1'b0);
      push_text("+IPD,2:");
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b1);
      push_text("++IPD");
      push_text("+IPD,0:");
      push_text("+IPD,7x");

      // random phases, alternating header mode
      for (phase_no = 0; phase_no < 6; phase_no++) begin
         write_mux(phase_no[0]);
         calm = (phase_no == 2);
         if (phase_no == 1) begin
            // large connection id saturates, payload of another stream
            push_text("+IPD,300,1:");
            push_byte("A", 1'b1);
         end
         if (phase_no == 4) begin
            // mode changed while the connection id was being read
            push_text("2,3:");
            repeat (3) push_byte(pick_byte(), pick_full());
         end
         target = sent + RANDOM_ITEMS / 6;
         while (sent < target) push_frame(phase_no[0]);
         if (phase_no == 3) push_text("+IPD,1");
      end
      calm = 1'b0;

      // saturated length, then a run of payload bytes all refused by the buffer
      write_mux(1'b0);
      push_text("\r\n+IPD,99999:");
      repeat (REFUSED_RUN) push_byte(pick_byte(), 1'b1);
      target = sent + 60;
      while (sent < target) push_frame(1'b0);

      drain();
      $display("checked %0d results for %0d requests in both header modes",
               board.checked, sent);
      $display("%0d headers announced, loss count ended at %0d",
               board.announced, board.loss_count);
      if (board.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end
endmodule
